### hdl/aesctr_pkg.sv
// ----------------------------------------------------------------------------
// aesctr_pkg
// Shared types, constants and AES-128 round functions for the CTR combiner.
// ----------------------------------------------------------------------------
package aesctr_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int LAST_ROUND  = 10;

   typedef struct packed {
      logic [7:0]  data;
      logic [3:0]  pos;
      logic [11:0] block;
   } item_type;

   typedef enum logic [1:0] {
      CSR_KEY_LOW  = 2'd0,
      CSR_KEY_HIGH = 2'd1,
      CSR_NONCE    = 2'd2,
      CSR_UNUSED   = 2'd3
   } csr_index_type;

   localparam logic [7:0] SBOX [0:255] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] rcon(input logic [3:0] round);
      logic [7:0] rc;
      unique case (round)
         4'd1:    rc = 8'h01;
         4'd2:    rc = 8'h02;
         4'd3:    rc = 8'h04;
         4'd4:    rc = 8'h08;
         4'd5:    rc = 8'h10;
         4'd6:    rc = 8'h20;
         4'd7:    rc = 8'h40;
         4'd8:    rc = 8'h80;
         4'd9:    rc = 8'h1b;
         4'd10:   rc = 8'h36;
         default: rc = 8'h00;
      endcase
      return rc;
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of a block sits in bits 8i+7..8i
   function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0]  t;
      logic [127:0] n;
      t = {SBOX[k[103:96]], SBOX[k[127:120]], SBOX[k[119:112]], SBOX[k[111:104]] ^ rc};
      n[31:0]   = k[31:0]   ^ t;
      n[63:32]  = k[63:32]  ^ n[31:0];
      n[95:64]  = k[95:64]  ^ n[63:32];
      n[127:96] = k[127:96] ^ n[95:64];
      return n;
   endfunction

   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                              input logic last);
      logic [127:0] t;
      logic [127:0] m;
      logic [7:0]   a0, a1, a2, a3, all;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[8*(c*4+r) +: 8] = SBOX[s[8*((((c+r)%4)*4)+r) +: 8]];
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0  = t[8*(c*4)   +: 8];
         a1  = t[8*(c*4+1) +: 8];
         a2  = t[8*(c*4+2) +: 8];
         a3  = t[8*(c*4+3) +: 8];
         all = a0 ^ a1 ^ a2 ^ a3;
         m[8*(c*4)   +: 8] = a0 ^ all ^ xtime(a0 ^ a1);
         m[8*(c*4+1) +: 8] = a1 ^ all ^ xtime(a1 ^ a2);
         m[8*(c*4+2) +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
         m[8*(c*4+3) +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
      end
      return (last ? t : m) ^ rk;
   endfunction

endpackage

### hdl/aesctr_front.sv
// ----------------------------------------------------------------------------
// aesctr_front
// Accepts request words, drops out-of-range offsets, queues the rest.
// ----------------------------------------------------------------------------
module aesctr_front #(
   parameter int unsigned MESSAGE_BYTES = 65536
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_data_byte,
   input  logic [15:0]          req_byte_offset,
   input  logic [16:0]          req_message_length,
   output logic                 head_valid,
   output aesctr_pkg::item_type head,
   input  logic                 head_pop
);
   import aesctr_pkg::*;

   item_type            queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                keep, push;

   assign req_ready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign keep = ({1'b0, req_byte_offset} < req_message_length) &&
                 (32'(req_byte_offset) < 32'(MESSAGE_BYTES));
   assign push = req_valid && req_ready && keep;

   assign head_valid = (count_ff != '0);
   assign head       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + (push ? 1'b1 : 1'b0);
      rd_ptr_in = rd_ptr_ff + (head_pop ? 1'b1 : 1'b0);
      count_in  = count_ff + (push ? 1'b1 : 1'b0) - (head_pop ? 1'b1 : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= '{data:  req_data_byte,
                                  pos:   req_byte_offset[3:0],
                                  block: req_byte_offset[15:4]};
      end
   end

endmodule

### hdl/aesctr_back.sv
// ----------------------------------------------------------------------------
// aesctr_back
// Keystream cache, iterative AES-128 engine and response register.
// ----------------------------------------------------------------------------
module aesctr_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [127:0]         key,
   input  logic [63:0]          nonce,
   input  logic                 cache_flush,
   input  logic                 head_valid,
   input  aesctr_pkg::item_type head,
   output logic                 head_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_out_byte
);
   import aesctr_pkg::*;

   typedef enum logic [1:0] {
      ST_SERVE = 2'b01,
      ST_CRYPT = 2'b10
   } state_type;

   state_type     state_ff, state_in;
   logic [3:0]    round_ff, round_in;
   logic [127:0]  aes_ff, aes_in, rk_ff, rk_in;
   logic [127:0]  ks_ff, ks_in;
   logic [11:0]   cblock_ff, cblock_in;
   logic          cvalid_ff, cvalid_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic [127:0]  rk_next, aes_next;
   logic          hit, out_free;

   assign hit      = cvalid_ff && (cblock_ff == head.block);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rk_next  = key_step(rk_ff, rcon(round_ff));
   assign aes_next = aes_round(aes_ff, rk_next, round_ff == 4'(LAST_ROUND));

   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      aes_in       = aes_ff;
      rk_in        = rk_ff;
      ks_in        = ks_ff;
      cblock_in    = cblock_ff;
      cvalid_in    = cvalid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      head_pop     = 1'b0;
      unique case (state_ff)
         ST_SERVE: begin
            if (head_valid && hit && out_free) begin
               head_pop     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_byte_in  = head.data ^ ks_ff[8*head.pos +: 8];
            end else if (head_valid && !hit) begin
               // counter block: nonce bytes, then block number little-endian
               aes_in   = {52'd0, head.block, nonce} ^ key;
               rk_in    = key;
               round_in = 4'd1;
               state_in = ST_CRYPT;
            end
         end
         ST_CRYPT: begin
            aes_in   = aes_next;
            rk_in    = rk_next;
            round_in = round_ff + 4'd1;
            if (round_ff == 4'(LAST_ROUND)) begin
               ks_in     = aes_next;
               cblock_in = head.block;
               cvalid_in = 1'b1;
               state_in  = ST_SERVE;
            end
         end
         default: state_in = ST_SERVE;
      endcase
      if (cache_flush) cvalid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SERVE;
         round_ff     <= '0;
         cvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         cvalid_ff    <= cvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      aes_ff      <= aes_in;
      rk_ff       <= rk_in;
      ks_ff       <= ks_in;
      cblock_ff   <= cblock_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;

   a_round_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CRYPT |-> round_ff >= 4'd1 && round_ff <= 4'(LAST_ROUND))
      else $error("round counter out of range");

   a_pop_on_hit: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> state_ff == ST_SERVE && hit && head_valid)
      else $error("pop without cache hit");

   a_fill_sets_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CRYPT && round_ff == 4'(LAST_ROUND) && !cache_flush |=>
      cvalid_ff && state_ff == ST_SERVE)
      else $error("cache fill lost");

endmodule

### hdl/aes128_ctr_random_access_xor.sv
// ----------------------------------------------------------------------------
// aes128_ctr_random_access_xor
// AES-128 CTR keystream combiner with random byte access and a block cache.
// ----------------------------------------------------------------------------
//  channel | ports                         | dir
//  req     | req_valid/ready, data, offset | in
//  rsp     | rsp_valid/ready, out_byte     | out
//  csr     | csr_write_enable/index/data   | in
//
// A byte whose block is cached passes the queue and the response register; one per cycle unless rsp_ready stalls.
// A new block is computed by the AES engine, one round per cycle.
// Offsets at or past length are dropped at the input. Synchronous reset.
// A 4-word queue lets the input run while the engine or the output stalls.
// ----------------------------------------------------------------------------
module aes128_ctr_random_access_xor #(
   parameter int unsigned MESSAGE_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic [15:0] req_byte_offset,
   input  logic [16:0] req_message_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data
);
   import aesctr_pkg::*;

   logic [63:0] key_low_ff, key_high_ff, nonce_ff;
   logic        flush;
   logic        head_valid, head_pop;
   item_type    head;

   always_comb begin
      flush = 1'b0;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_KEY_LOW, CSR_KEY_HIGH, CSR_NONCE: flush = 1'b1;
            default:                               flush = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         nonce_ff    <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_KEY_LOW:  key_low_ff  <= csr_write_data;
            CSR_KEY_HIGH: key_high_ff <= csr_write_data;
            CSR_NONCE:    nonce_ff    <= csr_write_data;
            default:      ;
         endcase
      end
   end

   aesctr_front #(.MESSAGE_BYTES(MESSAGE_BYTES)) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_byte_offset    (req_byte_offset),
      .req_message_length (req_message_length),
      .head_valid         (head_valid),
      .head               (head),
      .head_pop           (head_pop)
   );

   aesctr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .key          ({key_high_ff, key_low_ff}),
      .nonce        (nonce_ff),
      .cache_flush  (flush),
      .head_valid   (head_valid),
      .head         (head),
      .head_pop     (head_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte)
   );

endmodule

### bench/aes128_ctr_random_access_xor_tb.sv
// ----------------------------------------------------------------------------
// aes128_ctr_random_access_xor_tb
// Checks the CTR combiner against an AES-128 keystream predictor: directed
// table first, then random sequential runs and random-access edits, with
// random gaps and stalls on both channels and key/nonce changes between phases.
// ----------------------------------------------------------------------------
module aes128_ctr_random_access_xor_tb;
   import aesctr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic [15:0] req_byte_offset = '0;
   logic [16:0] req_message_length = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_write_data = '0;

   aes128_ctr_random_access_xor uut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   logic [63:0] key_lo_m, key_hi_m, nonce_m;
   logic [7:0]  expected_bytes[$];
   int          errors = 0;
   int          results_seen = 0;
   int          items_sent = 0;
   int          dropped = 0;
   bit          long_hold = 0;

   typedef struct {
      logic [7:0]  data;
      logic [15:0] offset;
      logic [16:0] length;
      int          want; // -1: predictor only, -2: no result
   } row_type;

   function automatic logic [7:0] gf_double(logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // AES-128 encrypt, byte i in bits 8i+7..8i
   function automatic logic [127:0] cipher_block(logic [127:0] key, logic [127:0] blk);
      logic [7:0] rk [0:175];
      logic [7:0] s [0:15];
      logic [7:0] t [0:15];
      logic [7:0] w0, w1, w2, w3, tmp, a0, a1, a2, a3, all;
      logic [7:0] rc [0:9];
      logic [127:0] res;
      rc = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};
      for (int i = 0; i < 16; i++) begin
         rk[i] = key[8*i +: 8];
         s[i]  = blk[8*i +: 8];
      end
      for (int i = 16; i < 176; i += 4) begin
         w0 = rk[i-4]; w1 = rk[i-3]; w2 = rk[i-2]; w3 = rk[i-1];
         if ((i % 16) == 0) begin
            tmp = w0;
            w0 = SBOX[w1] ^ rc[i/16 - 1];
            w1 = SBOX[w2];
            w2 = SBOX[w3];
            w3 = SBOX[tmp];
         end
         rk[i]   = rk[i-16] ^ w0;
         rk[i+1] = rk[i-15] ^ w1;
         rk[i+2] = rk[i-14] ^ w2;
         rk[i+3] = rk[i-13] ^ w3;
      end
      for (int i = 0; i < 16; i++) s[i] ^= rk[i];
      for (int r = 1; r <= 10; r++) begin
         for (int c = 0; c < 4; c++)
            for (int q = 0; q < 4; q++) t[c*4+q] = SBOX[s[((c+q)%4)*4+q]];
         for (int c = 0; c < 4; c++) begin
            a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
            all = a0 ^ a1 ^ a2 ^ a3;
            if (r != 10) begin
               s[c*4]   = a0 ^ all ^ gf_double(a0 ^ a1);
               s[c*4+1] = a1 ^ all ^ gf_double(a1 ^ a2);
               s[c*4+2] = a2 ^ all ^ gf_double(a2 ^ a3);
               s[c*4+3] = a3 ^ all ^ gf_double(a3 ^ a0);
            end else begin
               s[c*4] = a0; s[c*4+1] = a1; s[c*4+2] = a2; s[c*4+3] = a3;
            end
         end
         for (int i = 0; i < 16; i++) s[i] ^= rk[r*16+i];
      end
      for (int i = 0; i < 16; i++) res[8*i +: 8] = s[i];
      return res;
   endfunction

   // returns -1 when the offset is dropped
   function automatic int keystream_xor(logic [7:0] d, logic [15:0] off, logic [16:0] len);
      logic [127:0] ks;
      if ({1'b0, off} >= len) return -1;
      ks = cipher_block({key_hi_m, key_lo_m}, {52'd0, off[15:4], nonce_m});
      return int'(d ^ ks[8*off[3:0] +: 8]);
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      errors++;
      $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
   endtask

   task automatic csr_write(csr_index_type idx, logic [63:0] val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_KEY_LOW:  key_lo_m = val;
         CSR_KEY_HIGH: key_hi_m = val;
         CSR_NONCE:    nonce_m = val;
         default: ;
      endcase
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(negedge clock);
      repeat (16) @(negedge clock); // drops may still be in flight
   endtask

   // valid stays high into the next word when there is no gap
   task automatic send_word(logic [7:0] d, logic [15:0] off, logic [16:0] len, int want,
                            bit nogap);
      int p;
      int gap;
      gap = nogap ? 0 : $urandom_range(17);
      if ($urandom_range(3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      p = keystream_xor(d, off, len);
      if (want >= 0 && p != want) report_mismatch("predictor", p, want);
      if (want == -2 && p != -1) report_mismatch("predictor drop", p, -1);
      req_valid <= 1'b1;
      req_data_byte <= d;
      req_byte_offset <= off;
      req_message_length <= len;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (p >= 0) expected_bytes.push_back(p[7:0]);
      else dropped++;
      items_sent++;
      @(negedge clock);
   endtask

   // receiver
   initial begin
      int st;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (60) @(negedge clock);
            long_hold = 0;
         end
         st = ($urandom_range(3) == 0) ? 0 : $urandom_range(17);
         if (st > 0) begin
            rsp_ready <= 1'b0;
            repeat (st - 1) @(negedge clock);
            @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // output checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_bytes.size() == 0) report_mismatch("unexpected out_byte", rsp_out_byte, 0);
         else begin
            logic [7:0] e;
            e = expected_bytes.pop_front();
            if (rsp_out_byte !== e) report_mismatch("out_byte", rsp_out_byte, e);
         end
      end
   end

   initial begin
      #60ms;
      $display("Regression FAIL");
      $finish;
   end

   row_type table_rows[$];
   logic [15:0] base;
   logic [16:0] len_r;

   initial begin
      key_lo_m = '0; key_hi_m = '0; nonce_m = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all-zero key and counter block: keystream starts 66 e9 4b d4 ...
      table_rows = '{
         '{8'h00, 16'd0,     17'd1,      8'h66},
         '{8'hff, 16'd1,     17'd2,      8'h16},
         '{8'h00, 16'd2,     17'd16,     8'h4b},
         '{8'h00, 16'd3,     17'd65536,  8'hd4},
         '{8'h55, 16'd0,     17'd0,      -2},
         '{8'h55, 16'd5,     17'd5,      -2},
         '{8'h12, 16'd65535, 17'd65535,  -2},
         '{8'h34, 16'd65535, 17'd65536,  -1},
         '{8'h34, 16'd65535, 17'h1ffff,  -1},
         '{8'h56, 16'd15,    17'd16,     -1},
         '{8'h78, 16'd16,    17'd17,     -1},
         '{8'h9a, 16'd17,    17'd100,    -1},
         '{8'hbc, 16'd4,     17'd100,    -1},
         '{8'hde, 16'h8000,  17'h10000,  -1},
         '{8'hf0, 16'd4095,  17'd4096,   -1}
      };
      foreach (table_rows[i])
         send_word(table_rows[i].data, table_rows[i].offset, table_rows[i].length,
                   table_rows[i].want, 0);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               csr_write(CSR_KEY_LOW, '1); csr_write(CSR_KEY_HIGH, '1); csr_write(CSR_NONCE, '1);
            end
            1: begin
               csr_write(CSR_KEY_LOW, 64'h0706050403020100);
               csr_write(CSR_KEY_HIGH, 64'h0f0e0d0c0b0a0908);
               csr_write(CSR_NONCE, '0);
               csr_write(CSR_UNUSED, 64'hdead);
            end
            default: begin
               csr_write(CSR_KEY_LOW, {$urandom, $urandom});
               csr_write(CSR_KEY_HIGH, {$urandom, $urandom});
               csr_write(CSR_NONCE, {$urandom, $urandom});
            end
         endcase
         if (phase == 2) long_hold = 1;
         for (int run = 0; run < 9; run++) begin
            base = (run % 3 == 0) ? 16'($urandom) : 16'($urandom_range(200));
            len_r = 17'(base) + 17'($urandom_range(40, 1));
            if (run % 4 == 3) begin
               // random-access edits, some past length
               for (int k = 0; k < 64; k++)
                  send_word(8'($urandom), 16'($urandom_range(base + 60, base)),
                            17'($urandom_range(int'(len_r) + 4)), -1, long_hold);
            end else begin
               for (int o = base; o < len_r && o < 65536; o++)
                  send_word(8'($urandom), 16'(o), len_r, -1, long_hold);
            end
            if (run == 4) drain(); // sender pause until all results are back
         end
         drain();
      end
      drain();
      $display("Covered %0d words (%0d dropped past length), %0d results checked",
               items_sent, dropped, results_seen);
      $display("over 7 key/nonce settings incl. all-zero and all-one, random gaps and stalls");
      if (errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
